>>> hw/rtl/gregorian_date_add_days_assert.svh
// Assertion macros for the Gregorian date adder; empty when synthesizing.
`ifndef GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`define GREGORIAN_DATE_ADD_DAYS_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define GDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gregorian_date_add_days check failed");
// Next-cycle implication.
`define GDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gregorian_date_add_days check failed");
`else
`define GDA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GDA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hw/rtl/gda_pkg.sv
// Shared types, constants and calendar functions of the Gregorian date adder.
package gda_pkg;

    localparam int ADD_DAYS_BITS_DEF = 16;
    localparam int DAY_W             = 5;
    localparam int MONTH_W           = 4;
    localparam int YEAR_IN_W         = 14;
    localparam int PC_W              = 4;
    localparam int CIDX_W            = 3;
    localparam int DOY_W             = 9;

    // Datapath operation selected by the current control word.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_REDUCE,
        OP_OFFSET,
        OP_YEAR,
        OP_MONTH,
        OP_EMIT
    } ucode_op_t;

    // How the step counter advances after the current control word.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_WAIT_IN,
        COND_LOOP,
        COND_WAIT_OUT,
        COND_JUMP
    } ucode_cond_t;

    typedef struct packed {
        ucode_op_t          op;
        ucode_cond_t        cond;
        logic [CIDX_W-1:0]  cidx;
        logic [PC_W-1:0]    tgt;
    } ucode_word_t;

    typedef struct packed {
        logic in_fire;
        logic out_free;
        logic loop;
    } seq_status_t;

    // Days in the months before month m; zero for codes outside 1..12.
    function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of month m, with February following the leap flag.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] d;
        unique case (m)
            4'd2:                      d = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
            default:                   d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

>>> hw/rtl/gda_seq.sv
// Step counter and microcode store that sequence the date adder datapath.
module gda_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gda_pkg::seq_status_t status,
    output gda_pkg::ucode_word_t ctrl
);
    import gda_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    // The program: take a word, reduce the year modulo 400, form the day of
    // the year plus the count, step over whole years, then over months, and emit.
    always_comb
    begin
        unique case (pc_reg)
            4'd0:    ctrl = '{OP_ACCEPT, COND_WAIT_IN,  3'd0, 4'd0};
            4'd1:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd0, 4'd0};
            4'd2:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd1, 4'd0};
            4'd3:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd2, 4'd0};
            4'd4:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd3, 4'd0};
            4'd5:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd4, 4'd0};
            4'd6:    ctrl = '{OP_REDUCE, COND_NEXT,     3'd5, 4'd0};
            4'd7:    ctrl = '{OP_OFFSET, COND_NEXT,     3'd0, 4'd0};
            4'd8:    ctrl = '{OP_YEAR,   COND_LOOP,     3'd0, 4'd8};
            4'd9:    ctrl = '{OP_MONTH,  COND_LOOP,     3'd0, 4'd9};
            4'd10:   ctrl = '{OP_EMIT,   COND_WAIT_OUT, 3'd0, 4'd0};
            default: ctrl = '{OP_NOP,    COND_JUMP,     3'd0, 4'd0};
        endcase
    end

    assign pc_inc = pc_reg + 4'd1;

    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:     pc_next = pc_inc;
            COND_WAIT_IN:  pc_next = status.in_fire ? pc_inc : pc_reg;
            COND_LOOP:     pc_next = status.loop ? ctrl.tgt : pc_inc;
            COND_WAIT_OUT: pc_next = status.out_free ? ctrl.tgt : pc_reg;
            COND_JUMP:     pc_next = ctrl.tgt;
            default:       pc_next = ctrl.tgt;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= '0;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hw/rtl/gda_dpath.sv
// Datapath of the date adder: year residue, running day count, year and month.
module gda_dpath #(
    parameter int ADD_DAYS_BITS = gda_pkg::ADD_DAYS_BITS_DEF,
    parameter int YEAR_W        = 15
) (
    input  logic                          clk,
    input  gda_pkg::ucode_word_t          ctrl,
    input  logic                          in_fire,
    input  logic [gda_pkg::DAY_W-1:0]     start_day,
    input  logic [gda_pkg::MONTH_W-1:0]   start_month,
    input  logic [gda_pkg::YEAR_IN_W-1:0] start_year,
    input  logic [ADD_DAYS_BITS-1:0]      days_to_add,
    output logic                          loop,
    output logic [gda_pkg::DAY_W-1:0]     res_day,
    output logic [gda_pkg::MONTH_W-1:0]   res_month,
    output logic [gda_pkg::YEAR_IN_W-1:0] res_year
);
    import gda_pkg::*;

    // The running count holds a day of the year (up to 366) plus the full count,
    // so it needs one bit above the wider of the two.
    localparam int ACC_W      = ((ADD_DAYS_BITS > DOY_W) ? ADD_DAYS_BITS : DOY_W) + 1;
    localparam int REDUCE_TOP = 12800;

    logic [DAY_W-1:0]         day_reg;
    logic [MONTH_W-1:0]       mon_reg;
    logic [MONTH_W-1:0]       mon_next;
    logic [YEAR_W-1:0]        year_reg;
    logic [YEAR_W-1:0]        year_next;
    logic [YEAR_IN_W-1:0]     ymod_reg;
    logic [YEAR_IN_W-1:0]     ymod_next;
    logic [ADD_DAYS_BITS-1:0] days_reg;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;

    logic                     leap;
    logic [ACC_W-1:0]         ylen;
    logic [ACC_W-1:0]         mlen;
    logic [YEAR_IN_W-1:0]     red_const;
    logic                     year_over;
    logic                     month_over;

    // ymod_reg holds the year modulo 400 once the reduction steps are done,
    // so the century rules become compares against a few constants.
    assign leap = (ymod_reg == '0)
               || ((ymod_reg[1:0] == 2'd0) && (ymod_reg != 14'd100)
                   && (ymod_reg != 14'd200) && (ymod_reg != 14'd300));

    assign ylen       = leap ? ACC_W'(366) : ACC_W'(365);
    assign mlen       = ACC_W'(month_days(mon_reg, leap));
    assign red_const  = YEAR_IN_W'(REDUCE_TOP) >> ctrl.cidx;
    assign year_over  = acc_reg > ylen;
    assign month_over = acc_reg > mlen;

    assign loop = ((ctrl.op == OP_YEAR) && year_over)
               || ((ctrl.op == OP_MONTH) && month_over && (mon_reg != 4'd12));

    always_comb
    begin
        acc_next  = acc_reg;
        mon_next  = mon_reg;
        year_next = year_reg;
        ymod_next = ymod_reg;
        unique case (ctrl.op)
            OP_ACCEPT:
            begin
                mon_next  = start_month;
                year_next = YEAR_W'(start_year);
                ymod_next = start_year;
            end
            OP_REDUCE:
            begin
                if (ymod_reg >= red_const)
                begin
                    ymod_next = ymod_reg - red_const;
                end
            end
            OP_OFFSET:
            begin
                acc_next = ACC_W'(day_reg) + ACC_W'(days_before(mon_reg))
                         + ACC_W'(leap && (mon_reg > 4'd2)) + ACC_W'(days_reg);
                mon_next = 4'd1;
            end
            OP_YEAR:
            begin
                if (year_over)
                begin
                    acc_next  = acc_reg - ylen;
                    year_next = year_reg + YEAR_W'(1);
                    ymod_next = (ymod_reg == 14'd399) ? '0 : ymod_reg + 14'd1;
                end
            end
            OP_MONTH:
            begin
                if (month_over)
                begin
                    acc_next = acc_reg - mlen;
                    mon_next = mon_reg + 4'd1;
                end
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            day_reg  <= start_day;
            days_reg <= days_to_add;
        end
        acc_reg  <= acc_next;
        mon_reg  <= mon_next;
        year_reg <= year_next;
        ymod_reg <= ymod_next;
    end

    assign res_day   = acc_reg[DAY_W-1:0];
    assign res_month = mon_reg;
    assign res_year  = year_reg[YEAR_IN_W-1:0];

endmodule

>>> hw/rtl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: stream ports, sequencer, datapath, output register.
//
// Usage: one input word carries a start date and a day count; one output word
// carries the date that lies that many days later (leap years by the 4, 100
// and 400 rule; a count that ends exactly on a year boundary gives December 31).
// Input channel s_axis_*: a word is taken when s_axis_tvalid and s_axis_tready
// are both high. Output channel m_axis_*: the result word is held until the
// receiver takes it with m_axis_tready.
// The year loop of the microcoded sequencer steps one year per cycle; the
// number of whole years stepped is at most about 180 for a 16-bit count,
// and the number of months stepped is at most 11. One word is in flight at
// a time: the next word is not taken until the last result has moved into
// the output register.
// s_axis_tready is high only while the sequencer waits at its first step.
// A finished result sits in the output register, so the next word can be
// accepted while the receiver stalls; if a second result is ready before the
// first is taken, the sequencer holds at its last step until the register
// frees. Reset (rst_n low) returns the sequencer to its first step and empties
// the output register; there is no other state to clear.
`include "gregorian_date_add_days_assert.svh"

module gregorian_date_add_days #(
    parameter int  ADD_DAYS_BITS = gda_pkg::ADD_DAYS_BITS_DEF,
    localparam int IN_TDATA_W    = ((gda_pkg::DAY_W + gda_pkg::MONTH_W
                                     + gda_pkg::YEAR_IN_W + ADD_DAYS_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_W   = ((gda_pkg::DAY_W + gda_pkg::MONTH_W
                                     + gda_pkg::YEAR_IN_W + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_day[4:0], start_month[8:5], start_year[22:9], days_to_add, then zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // out_day[4:0], out_month[8:5], out_year[22:9], then zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);
    import gda_pkg::*;

    localparam int YEAR_W = $clog2((1 << YEAR_IN_W) + (1 << ADD_DAYS_BITS) / 365 + 4);
    localparam int MON_LO = DAY_W;
    localparam int YR_LO  = DAY_W + MONTH_W;
    localparam int DAYS_LO = DAY_W + MONTH_W + YEAR_IN_W;
    localparam int OUT_USED = DAY_W + MONTH_W + YEAR_IN_W;

    ucode_word_t           ctrl;
    seq_status_t           status;
    logic                  in_fire;
    logic                  out_free;
    logic                  out_load;
    logic                  loop;
    logic [DAY_W-1:0]      res_day;
    logic [MONTH_W-1:0]    res_month;
    logic [YEAR_IN_W-1:0]  res_year;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [DAY_W-1:0]      out_day_reg;
    logic [MONTH_W-1:0]    out_month_reg;
    logic [YEAR_IN_W-1:0]  out_year_reg;

    // Handshake glue: input is taken only at the wait step; the result moves
    // into the output register when it is empty or being drained this cycle.
    assign s_axis_tready = (ctrl.op == OP_ACCEPT);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign out_load      = (ctrl.op == OP_EMIT) && out_free;

    assign status = '{in_fire: in_fire, out_free: out_free, loop: loop};

    gda_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    gda_dpath #(
        .ADD_DAYS_BITS (ADD_DAYS_BITS),
        .YEAR_W        (YEAR_W)
    ) u_dpath (
        .clk         (clk),
        .ctrl        (ctrl),
        .in_fire     (in_fire),
        .start_day   (s_axis_tdata[DAY_W-1:0]),
        .start_month (s_axis_tdata[YR_LO-1:MON_LO]),
        .start_year  (s_axis_tdata[DAYS_LO-1:YR_LO]),
        .days_to_add (s_axis_tdata[DAYS_LO+ADD_DAYS_BITS-1:DAYS_LO]),
        .loop        (loop),
        .res_day     (res_day),
        .res_month   (res_month),
        .res_year    (res_year)
    );

    always_comb
    begin
        priority if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_day_reg   <= res_day;
            out_month_reg <= res_month;
            out_year_reg  <= res_year;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED){1'b0}},
                            out_year_reg, out_month_reg, out_day_reg};

    // A delivered month is always January through December; the check also
    // lets code 13 through.
    `GDA_ASSERT_IMP(a_month_range, clk, rst_n, m_axis_tvalid, (out_month_reg != 4'd0) && (out_month_reg <= 4'd13))
    // Only one word is worked on at a time: after a take, input closes.
    `GDA_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_fire, !s_axis_tready)
    // A result loaded into the output register is presented next cycle.
    `GDA_ASSERT_NXT(a_emit_shows, clk, rst_n, out_load, m_axis_tvalid)
    // A result that cannot be loaded keeps the sequencer at its final step.
    `GDA_ASSERT_NXT(a_emit_holds, clk, rst_n, (ctrl.op == OP_EMIT) && !out_free, ctrl.op == OP_EMIT)

endmodule
